>>> design/assert_macros.svh
// Assertion macros shared by the gradient magnitude filter RTL.
// Standalone header; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gmf assertion failed");
`define GMF_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("gmf assertion failed");
`else
`define GMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GMF_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif
`endif

>>> design/gmf_pkg.sv
// Types and constants of the gradient magnitude filter.
// No dependencies; used by the interfaces and the top level.
package gmf_pkg;

	localparam int PIXEL_BITS     = 8;
	localparam int SIZE_BITS      = 12;
	localparam int WIN            = 3;
	localparam int TAPS           = WIN * WIN;
	localparam int FIFO_DEPTH     = 8;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;
	localparam int DEF_COEF_BITS  = 4;

	localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(640);
	localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(480);
	localparam logic [PIXEL_BITS-1:0] EDGE_MAX    = '1;

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_KERNEL_X     = 2'd2,
		CFG_KERNEL_Y     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] value;
		logic                  eor;
		logic                  last;
	} edge_word_t;

endpackage

>>> design/gmf_if.sv
// Stream interfaces of the gradient magnitude filter: pixel words in, edge words out.
// Depends on gmf_pkg.
interface gmf_pix_if
	import gmf_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;
	logic                  drain;

	modport source (output valid, pixel, drain, input ready);
	modport sink (input valid, pixel, drain, output ready);
endinterface

interface gmf_edge_if
	import gmf_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] edge_value;
	logic                  end_of_row;
	logic                  last_of_image;

	modport source (output valid, edge_value, end_of_row, last_of_image, input ready);
	modport sink (input valid, edge_value, end_of_row, last_of_image, output ready);
endinterface

>>> design/gradient_magnitude_filter_top.sv
// Gradient magnitude filter: 3x3 correlation with two signed kernels, |Gx|+|Gy| clipped to 255.
// Throughput is one word per cycle while the output queue has credit; the line stores are read every cycle.
// A result passes pipeline stages 1 to 4 and enters the output queue from stage 4 after its last
// contributing word is accepted; results lag the input stream by one row plus one pixel.
// Reset clears position, window, pipeline and queue, and sets the size registers to 640x480
// with zero kernels. The line stores are not cleared; rows outside the image read as zero.
`include "assert_macros.svh"

module gradient_magnitude_filter_top
	import gmf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int COEF_BITS  = DEF_COEF_BITS,
	localparam int KernBits  = TAPS * COEF_BITS,
	localparam int CfgBits   = (KernBits > SIZE_BITS) ? KernBits : SIZE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	gmf_pix_if.sink             pix_in,
	gmf_edge_if.source          edge_out,
	input  logic                cfg_we,
	input  cfg_reg_t            cfg_index,
	input  logic [CfgBits-1:0]  cfg_wdata
);

	// Column and row counter widths; the row counter runs one past the image
	// height while the trailing row is flushed.
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT + 2);
	localparam int CmpA  = (CW > RW) ? CW : RW;
	localparam int CmpB  = (CmpA > SIZE_BITS) ? CmpA : SIZE_BITS;
	localparam int CmpW  = CmpB + 2;
	// Arithmetic widths: pixel as a signed 9-bit value times a tap, nine products summed.
	localparam int ProdW = PIXEL_BITS + 1 + COEF_BITS;
	localparam int SumW  = ProdW + $clog2(TAPS);
	localparam int MagW  = SumW + 1;
	localparam int CntW  = FIFO_AW + 1;

	// Configuration registers.
	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;
	logic [KernBits-1:0]  kern_x_q;
	logic [KernBits-1:0]  kern_y_q;
	logic                 size_write;

	// Effective sizes: zero acts as one, large values clip to the store size.
	logic [CmpW-1:0] w_eff;
	logic [CmpW-1:0] h_eff;

	// Raster position of the next accepted word.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Accept stage decode.
	logic            acc;
	logic            take;
	logic [CmpW-1:0] col_w;
	logic [CmpW-1:0] row_w;
	logic [CmpW-1:0] col_inc;
	logic            row_in_img;
	logic            upv_c, midv_c, emit_c, last_c, wrap_c;

	// Line stores, one entry per column.
	logic [PIXEL_BITS-1:0] mem_up [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] mem_mid [MAX_WIDTH];

	// Stage 1: store read data arrives, window updates, store write-back.
	logic                  v_s1;
	logic [CW-1:0]         col_s1;
	logic [PIXEL_BITS-1:0] cur_s1;
	logic [PIXEL_BITS-1:0] rd_up_s1;
	logic [PIXEL_BITS-1:0] rd_mid_s1;
	logic                  upv_s1, midv_s1, emit_s1, eor_s1, last_s1;
	logic                  fwd_s1;
	logic [PIXEL_BITS-1:0] fwd_up_s1;
	logic [PIXEL_BITS-1:0] fwd_mid_s1;
	logic [PIXEL_BITS-1:0] up_c;
	logic [PIXEL_BITS-1:0] mid_c;

	logic [PIXEL_BITS-1:0] win_q [WIN][WIN];
	logic [PIXEL_BITS-1:0] win_n [WIN][WIN];
	logic [PIXEL_BITS-1:0] a_c [TAPS];

	// Stage 2: the window the result is taken from.
	logic                  v_s2, eor_s2, last_s2;
	logic [PIXEL_BITS-1:0] a_s2 [TAPS];

	// Stage 3: products.
	logic                    v_s3, eor_s3, last_s3;
	logic signed [ProdW-1:0] prod_x_c [TAPS];
	logic signed [ProdW-1:0] prod_y_c [TAPS];
	logic signed [ProdW-1:0] prod_x_s3 [TAPS];
	logic signed [ProdW-1:0] prod_y_s3 [TAPS];

	// Stage 4: kernel sums.
	logic                   v_s4, eor_s4, last_s4;
	logic signed [SumW-1:0] gx_c, gy_c;
	logic signed [SumW-1:0] gx_s4, gy_s4;
	logic [SumW-1:0]        abs_x, abs_y;
	logic [MagW-1:0]        mag;
	edge_word_t             word_c;

	// Output queue. Words are only admitted while every result that may still
	// come out of the pipeline has a free queue slot, so the pipeline never stalls.
	edge_word_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]      cnt_q;
	logic                 push, pop;
	logic [2:0]           inflight;
	logic [CntW:0]        credit_used;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	assign size_write = cfg_we &&
		(cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			kern_x_q <= '0;
			kern_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata[SIZE_BITS-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_wdata[SIZE_BITS-1:0];
				CFG_KERNEL_X:     kern_x_q <= cfg_wdata[KernBits-1:0];
				CFG_KERNEL_Y:     kern_y_q <= cfg_wdata[KernBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			w_eff = CmpW'(1);
		else if (CmpW'(width_q) > CmpW'(MAX_WIDTH))
			w_eff = CmpW'(MAX_WIDTH);
		else
			w_eff = CmpW'(width_q);
		if (height_q == '0)
			h_eff = CmpW'(1);
		else if (CmpW'(height_q) > CmpW'(MAX_HEIGHT))
			h_eff = CmpW'(MAX_HEIGHT);
		else
			h_eff = CmpW'(height_q);
	end

	// ------------------------------------------------------------------
	// Accept stage: position decode and counters
	// ------------------------------------------------------------------
	assign credit_used    = (CntW+1)'(cnt_q) + (CntW+1)'(inflight);
	assign pix_in.ready   = credit_used < (CntW+1)'(FIFO_DEPTH);
	assign acc            = pix_in.valid && pix_in.ready;

	always_comb begin
		col_w      = CmpW'(col_q);
		row_w      = CmpW'(row_q);
		col_inc    = col_w + CmpW'(1);
		row_in_img = row_w < h_eff;
		// A drain word while pixels are still expected is taken and dropped.
		take       = acc && !(row_in_img && pix_in.drain);
		upv_c      = (row_w >= CmpW'(2)) && (row_w < h_eff + CmpW'(2));
		midv_c     = (row_w >= CmpW'(1)) && (row_w < h_eff + CmpW'(1));
		emit_c     = (row_w >= CmpW'(2)) || (row_w == CmpW'(1) && col_w != '0);
		last_c     = (row_w == h_eff + CmpW'(1)) && (col_w == '0);
		wrap_c     = col_inc >= w_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (size_write) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last_c) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap_c) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Line stores: read every cycle at the current column, write back from stage 1.
	// With a one-pixel row the next word reads the entry being written in the
	// same cycle; that case is caught and the write data forwarded.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem_up[col_s1]  <= mid_c;
			mem_mid[col_s1] <= cur_s1;
		end
		rd_up_s1  <= mem_up[col_q];
		rd_mid_s1 <= mem_mid[col_q];
	end

	always_ff @(posedge clk) begin
		col_s1     <= col_q;
		cur_s1     <= row_in_img ? pix_in.pixel : '0;
		upv_s1     <= upv_c;
		midv_s1    <= midv_c;
		emit_s1    <= emit_c;
		eor_s1     <= (col_q == '0);
		last_s1    <= last_c;
		fwd_s1     <= v_s1 && (col_s1 == col_q);
		fwd_up_s1  <= mid_c;
		fwd_mid_s1 <= cur_s1;
	end

	// ------------------------------------------------------------------
	// Stage 1: window
	// ------------------------------------------------------------------
	always_comb begin
		up_c  = upv_s1 ? (fwd_s1 ? fwd_up_s1 : rd_up_s1) : '0;
		mid_c = midv_s1 ? (fwd_s1 ? fwd_mid_s1 : rd_mid_s1) : '0;
	end

	always_comb begin
		win_n = win_q;
		for (int r = 0; r < WIN; r++) begin
			if (eor_s1) begin
				// First column of a row: the previous row ends with a zero right column.
				a_c[r*WIN]     = win_q[r][1];
				a_c[r*WIN + 1] = win_q[r][2];
				a_c[r*WIN + 2] = '0;
				win_n[r][0]    = '0;
				win_n[r][1]    = '0;
			end else begin
				win_n[r][0]    = win_q[r][1];
				win_n[r][1]    = win_q[r][2];
				a_c[r*WIN]     = win_q[r][1];
				a_c[r*WIN + 1] = win_q[r][2];
				a_c[r*WIN + 2] = '0;
			end
		end
		win_n[0][2] = up_c;
		win_n[1][2] = mid_c;
		win_n[2][2] = cur_s1;
		if (!eor_s1) begin
			a_c[2] = up_c;
			a_c[5] = mid_c;
			a_c[8] = cur_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < WIN; r++)
				for (int c = 0; c < WIN; c++)
					win_q[r][c] <= '0;
		end else if (size_write) begin
			for (int r = 0; r < WIN; r++)
				for (int c = 0; c < WIN; c++)
					win_q[r][c] <= '0;
		end else if (v_s1) begin
			win_q <= win_n;
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 to 4: products, sums, magnitude
	// ------------------------------------------------------------------
	always_comb begin
		logic signed [COEF_BITS-1:0] tx;
		logic signed [COEF_BITS-1:0] ty;
		for (int k = 0; k < TAPS; k++) begin
			tx          = $signed(kern_x_q[k*COEF_BITS +: COEF_BITS]);
			ty          = $signed(kern_y_q[k*COEF_BITS +: COEF_BITS]);
			prod_x_c[k] = ProdW'($signed({1'b0, a_s2[k]})) * ProdW'(tx);
			prod_y_c[k] = ProdW'($signed({1'b0, a_s2[k]})) * ProdW'(ty);
		end
	end

	always_comb begin
		gx_c = '0;
		gy_c = '0;
		for (int k = 0; k < TAPS; k++) begin
			gx_c = gx_c + SumW'(prod_x_s3[k]);
			gy_c = gy_c + SumW'(prod_y_s3[k]);
		end
	end

	always_comb begin
		abs_x        = gx_s4[SumW-1] ? SumW'(-gx_s4) : SumW'(gx_s4);
		abs_y        = gy_s4[SumW-1] ? SumW'(-gy_s4) : SumW'(gy_s4);
		mag          = MagW'(abs_x) + MagW'(abs_y);
		word_c.value = (mag > MagW'(EDGE_MAX)) ? EDGE_MAX : mag[PIXEL_BITS-1:0];
		word_c.eor   = eor_s4;
		word_c.last  = last_s4;
	end

	always_ff @(posedge clk) begin
		a_s2      <= a_c;
		eor_s2    <= eor_s1;
		last_s2   <= last_s1;
		prod_x_s3 <= prod_x_c;
		prod_y_s3 <= prod_y_c;
		eor_s3    <= eor_s2;
		last_s3   <= last_s2;
		gx_s4     <= gx_c;
		gy_s4     <= gy_c;
		eor_s4    <= eor_s3;
		last_s4   <= last_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Output queue
	// ------------------------------------------------------------------
	assign inflight = 3'(v_s1 && emit_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign push     = v_s4;
	assign pop      = edge_out.valid && edge_out.ready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= word_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CntW'(1);
				2'b01:   cnt_q <= cnt_q - CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign edge_out.valid         = (cnt_q != '0);
	assign edge_out.edge_value    = fifo_q[rd_ptr_q].value;
	assign edge_out.end_of_row    = fifo_q[rd_ptr_q].eor;
	assign edge_out.last_of_image = fifo_q[rd_ptr_q].last;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`GMF_ASSERT_IMPL(a_fifo_no_overflow, clk, arst_n, push && !pop, cnt_q < CntW'(FIFO_DEPTH))
	`GMF_ASSERT_ALWAYS(a_credit_bound, clk, arst_n, credit_used <= (CntW+1)'(FIFO_DEPTH))
	`GMF_ASSERT_IMPL(a_col_in_row, clk, arst_n, v_s1, CmpW'(col_s1) < w_eff)
	`GMF_ASSERT_IMPL(a_fwd_same_col, clk, arst_n, v_s1 && fwd_s1, col_s1 == $past(col_s1))
	`GMF_ASSERT_IMPL(a_last_ends_row, clk, arst_n, edge_out.valid && edge_out.last_of_image, edge_out.end_of_row)

endmodule
